// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the RTL of the disc pair collision block.
// No dependencies; define NO_ASSERTIONS to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_ALWAYS(label, clk, rst_n, cond)
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- rtl/dpcr_pkg.sv -----
// Types, constants and helper functions of the disc pair collision block.
// Used by every module under rtl; depends on nothing.
package dpcr_pkg;

    localparam int FRAC_BITS = 16;
    localparam int POS_W     = 32;
    localparam int RAD_W     = 24;
    localparam int RSUM_W    = RAD_W + 1;
    localparam int MAG_W     = 25;
    localparam int SQ_W      = 2 * MAG_W;
    localparam int DSQ_W     = SQ_W + 1;
    localparam int DIST_W    = 26;
    localparam int QUO_W     = FRAC_BITS + 1;
    localparam int DAMP_W    = 17;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam int MIN_DIST_RAW = ((1 << FRAC_BITS) + 5000) / 10000;
    localparam int MIN_DIST     = (MIN_DIST_RAW == 0) ? 1 : MIN_DIST_RAW;
    localparam int FAR_LIMIT    = 33554432;

    localparam logic [DAMP_W-1:0] DAMP_ONE   = 17'd65536;
    localparam logic [DAMP_W-1:0] DAMP_RESET = 17'd52429;

    typedef struct packed {
        logic signed [POS_W-1:0] p1x;
        logic signed [POS_W-1:0] p1y;
        logic signed [POS_W-1:0] v1x;
        logic signed [POS_W-1:0] v1y;
        logic        [RAD_W-1:0] r1;
        logic signed [POS_W-1:0] p2x;
        logic signed [POS_W-1:0] p2y;
        logic signed [POS_W-1:0] v2x;
        logic signed [POS_W-1:0] v2y;
        logic        [RAD_W-1:0] r2;
    } dpcr_pair_t;

    typedef struct packed {
        dpcr_pair_t          pair;
        logic                hit;
        logic [RSUM_W-1:0]   rsum;
        logic                dx_neg;
        logic                dy_neg;
        logic [MAG_W-1:0]    ax;
        logic [MAG_W-1:0]    ay;
    } dpcr_item_t;

    typedef struct packed {
        dpcr_item_t        item;
        logic [DSQ_W-1:0]  dsq;
    } dpcr_qent_t;

    typedef struct packed {
        logic [QCNT_W-1:0] count;
        logic              full;
        logic              empty;
    } dpcr_qstat_t;

    typedef struct packed {
        dpcr_item_t         item;
        logic [DIST_W-1:0]  dlen;
        logic [QUO_W-1:0]   qx;
        logic [QUO_W-1:0]   qy;
    } dpcr_norm_t;

    typedef struct packed {
        logic                    hit;
        logic signed [POS_W-1:0] p1x;
        logic signed [POS_W-1:0] p1y;
        logic signed [POS_W-1:0] v1x;
        logic signed [POS_W-1:0] v1y;
        logic signed [POS_W-1:0] p2x;
        logic signed [POS_W-1:0] p2y;
        logic signed [POS_W-1:0] v2x;
        logic signed [POS_W-1:0] v2y;
    } dpcr_res_t;

    // Arithmetic right shift that rounds toward zero.
    function automatic logic signed [63:0] shr_tz(input logic signed [63:0] v,
                                                  input int unsigned s);
        logic signed [63:0] m;
        begin
            m = -v;
            if (v < 0)
            begin
                shr_tz = -(m >>> s);
            end
            else
            begin
                shr_tz = v >>> s;
            end
        end
    endfunction

    function automatic logic signed [POS_W-1:0] sat32(input logic signed [63:0] v);
        begin
            if (v > 64'sd2147483647)
            begin
                sat32 = 32'sh7FFFFFFF;
            end
            else if (v < -64'sd2147483648)
            begin
                sat32 = 32'sh80000000;
            end
            else
            begin
                sat32 = v[POS_W-1:0];
            end
        end
    endfunction

endpackage

// ----- rtl/dpcr_front.sv -----
// Front end: accepts a disc pair, forms offsets, squares and the hit test.
// Pushes classified transactions into the queue; uses dpcr_pkg.
module dpcr_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  dpcr_pkg::dpcr_pair_t in_pair,
    input  logic                q_full,
    output logic                q_push,
    output dpcr_pkg::dpcr_qent_t q_data
);
    import dpcr_pkg::*;

    localparam logic signed [POS_W:0] FAR_POS = (POS_W+1)'(FAR_LIMIT);
    localparam logic signed [POS_W:0] FAR_NEG = -FAR_POS;

    logic                    en;
    logic                    f1_v_reg;
    dpcr_pair_t              f1_pair_reg;
    logic signed [POS_W:0]   f1_dx_reg;
    logic signed [POS_W:0]   f1_dy_reg;
    logic [RSUM_W-1:0]       f1_rsum_reg;

    logic                    f2_v_reg;
    dpcr_item_t              f2_item_reg;
    logic                    f2_near_reg;
    logic [SQ_W-1:0]         f2_sqx_reg;
    logic [SQ_W-1:0]         f2_sqy_reg;
    logic [SQ_W-1:0]         f2_rsq_reg;

    logic                    near_next;
    logic signed [POS_W:0]   dx_abs;
    logic signed [POS_W:0]   dy_abs;
    dpcr_item_t              item_next;
    logic [DSQ_W-1:0]        dsq;

    assign en       = !f2_v_reg || !q_full;
    assign in_stall = !en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_v_reg <= 1'b0;
            f2_v_reg <= 1'b0;
        end
        else if (en)
        begin
            f1_v_reg <= in_valid;
            f2_v_reg <= f1_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f1_pair_reg <= in_pair;
            f1_dx_reg   <= (POS_W+1)'(in_pair.p2x) - (POS_W+1)'(in_pair.p1x);
            f1_dy_reg   <= (POS_W+1)'(in_pair.p2y) - (POS_W+1)'(in_pair.p1y);
            f1_rsum_reg <= RSUM_W'(in_pair.r1) + RSUM_W'(in_pair.r2);
        end
    end

    always_comb
    begin
        near_next = (f1_dx_reg < FAR_POS) && (f1_dx_reg > FAR_NEG) &&
                    (f1_dy_reg < FAR_POS) && (f1_dy_reg > FAR_NEG);
        dx_abs = f1_dx_reg[POS_W] ? -f1_dx_reg : f1_dx_reg;
        dy_abs = f1_dy_reg[POS_W] ? -f1_dy_reg : f1_dy_reg;
        item_next.pair   = f1_pair_reg;
        item_next.hit    = 1'b0;
        item_next.rsum   = f1_rsum_reg;
        item_next.dx_neg = f1_dx_reg[POS_W];
        item_next.dy_neg = f1_dy_reg[POS_W];
        item_next.ax     = near_next ? dx_abs[MAG_W-1:0] : '0;
        item_next.ay     = near_next ? dy_abs[MAG_W-1:0] : '0;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f2_item_reg <= item_next;
            f2_near_reg <= near_next;
            f2_sqx_reg  <= item_next.ax * item_next.ax;
            f2_sqy_reg  <= item_next.ay * item_next.ay;
            f2_rsq_reg  <= f1_rsum_reg * f1_rsum_reg;
        end
    end

    always_comb
    begin
        dsq         = DSQ_W'(f2_sqx_reg) + DSQ_W'(f2_sqy_reg);
        q_data.item = f2_item_reg;
        q_data.item.hit = f2_near_reg && (dsq < DSQ_W'(f2_rsq_reg));
        q_data.dsq  = dsq;
        q_push      = f2_v_reg && !q_full;
    end

endmodule

// ----- rtl/dpcr_queue.sv -----
// Short transaction queue between the front end and the back end.
// Register-based FIFO; uses dpcr_pkg.
module dpcr_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  dpcr_pkg::dpcr_qent_t push_data,
    input  logic                 pop,
    output dpcr_pkg::dpcr_qent_t pop_data,
    output dpcr_pkg::dpcr_qstat_t stat
);
    import dpcr_pkg::*;

    dpcr_qent_t          mem_reg [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QCNT_W-1:0]   count_reg;
    logic [QCNT_W-1:0]   count_next;

    always_comb
    begin
        count_next = count_reg + QCNT_W'(push) - QCNT_W'(pop);
        stat.count = count_reg;
        stat.full  = (count_reg == QCNT_W'(QDEPTH));
        stat.empty = (count_reg == '0);
        pop_data   = mem_reg[rd_ptr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ----- rtl/dpcr_norm.sv -----
// Back end, first half: pipelined square root of the squared distance and
// pipelined division that forms the unit normal magnitudes; uses dpcr_pkg.
module dpcr_norm (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  dpcr_pkg::dpcr_qent_t in_data,
    output logic                 out_valid,
    output dpcr_pkg::dpcr_norm_t out_data
);
    import dpcr_pkg::*;

    localparam int SQ_STEPS  = DIST_W;
    localparam int SQ_REM_W  = 2 * DIST_W;
    localparam int DIV_STEPS = QUO_W;
    localparam int DREM_W    = DIST_W + FRAC_BITS;

    logic                 sq_v_reg    [SQ_STEPS];
    dpcr_item_t           sq_item_reg [SQ_STEPS];
    logic [SQ_REM_W-1:0]  sq_rem_reg  [SQ_STEPS-1];
    logic [DIST_W-1:0]    sq_root_reg [SQ_STEPS];

    logic                 dv_v_reg    [DIV_STEPS];
    dpcr_item_t           dv_item_reg [DIV_STEPS];
    logic [DIST_W-1:0]    dv_dist_reg [DIV_STEPS];
    logic [DREM_W-1:0]    dv_remx_reg [DIV_STEPS-1];
    logic [DREM_W-1:0]    dv_remy_reg [DIV_STEPS-1];
    logic [QUO_W-1:0]     dv_qx_reg   [DIV_STEPS];
    logic [QUO_W-1:0]     dv_qy_reg   [DIV_STEPS];

    for (genvar s = 0; s < SQ_STEPS; s++)
    begin : g_sqrt
        localparam int B = SQ_STEPS - 1 - s;
        logic                v_in;
        dpcr_item_t          item_in;
        logic [SQ_REM_W-1:0] rem_in;
        logic [DIST_W-1:0]   root_in;
        logic [SQ_REM_W-1:0] trial;
        logic [SQ_REM_W-1:0] rem_next;
        logic [DIST_W-1:0]   root_next;

        if (s == 0)
        begin : g_first
            assign v_in    = in_valid;
            assign item_in = in_data.item;
            assign rem_in  = SQ_REM_W'(in_data.dsq);
            assign root_in = '0;
        end
        else
        begin : g_rest
            assign v_in    = sq_v_reg[s-1];
            assign item_in = sq_item_reg[s-1];
            assign rem_in  = sq_rem_reg[s-1];
            assign root_in = sq_root_reg[s-1];
        end

        always_comb
        begin
            trial = (SQ_REM_W'(root_in) << (B + 1)) | (SQ_REM_W'(1) << (2 * B));
            if (rem_in >= trial)
            begin
                rem_next  = rem_in - trial;
                root_next = root_in | (DIST_W'(1) << B);
            end
            else
            begin
                rem_next  = rem_in;
                root_next = root_in;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                sq_v_reg[s] <= 1'b0;
            end
            else if (en)
            begin
                sq_v_reg[s] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sq_item_reg[s] <= item_in;
                sq_root_reg[s] <= root_next;
            end
        end

        if (s < SQ_STEPS - 1)
        begin : g_rem
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    sq_rem_reg[s] <= rem_next;
                end
            end
        end
    end

    for (genvar s = 0; s < DIV_STEPS; s++)
    begin : g_div
        localparam int B = DIV_STEPS - 1 - s;
        logic              v_in;
        dpcr_item_t        item_in;
        logic [DIST_W-1:0] dist_in;
        logic [DREM_W-1:0] remx_in;
        logic [DREM_W-1:0] remy_in;
        logic [QUO_W-1:0]  qx_in;
        logic [QUO_W-1:0]  qy_in;
        logic [DREM_W-1:0] cmp;
        logic [DREM_W-1:0] remx_next;
        logic [DREM_W-1:0] remy_next;
        logic [QUO_W-1:0]  qx_next;
        logic [QUO_W-1:0]  qy_next;

        if (s == 0)
        begin : g_first
            logic [DIST_W-1:0] root;
            assign root    = sq_root_reg[SQ_STEPS-1];
            assign v_in    = sq_v_reg[SQ_STEPS-1];
            assign item_in = sq_item_reg[SQ_STEPS-1];
            assign dist_in = (root == '0) ? DIST_W'(MIN_DIST) : root;
            assign remx_in = DREM_W'({item_in.ax, {FRAC_BITS{1'b0}}});
            assign remy_in = DREM_W'({item_in.ay, {FRAC_BITS{1'b0}}});
            assign qx_in   = '0;
            assign qy_in   = '0;
        end
        else
        begin : g_rest
            assign v_in    = dv_v_reg[s-1];
            assign item_in = dv_item_reg[s-1];
            assign dist_in = dv_dist_reg[s-1];
            assign remx_in = dv_remx_reg[s-1];
            assign remy_in = dv_remy_reg[s-1];
            assign qx_in   = dv_qx_reg[s-1];
            assign qy_in   = dv_qy_reg[s-1];
        end

        always_comb
        begin
            cmp = DREM_W'(dist_in) << B;
            if (remx_in >= cmp)
            begin
                remx_next = remx_in - cmp;
                qx_next   = qx_in | (QUO_W'(1) << B);
            end
            else
            begin
                remx_next = remx_in;
                qx_next   = qx_in;
            end
            if (remy_in >= cmp)
            begin
                remy_next = remy_in - cmp;
                qy_next   = qy_in | (QUO_W'(1) << B);
            end
            else
            begin
                remy_next = remy_in;
                qy_next   = qy_in;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_v_reg[s] <= 1'b0;
            end
            else if (en)
            begin
                dv_v_reg[s] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dv_item_reg[s] <= item_in;
                dv_dist_reg[s] <= dist_in;
                dv_qx_reg[s]   <= qx_next;
                dv_qy_reg[s]   <= qy_next;
            end
        end

        if (s < DIV_STEPS - 1)
        begin : g_rem
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    dv_remx_reg[s] <= remx_next;
                    dv_remy_reg[s] <= remy_next;
                end
            end
        end
    end

    always_comb
    begin
        out_valid     = dv_v_reg[DIV_STEPS-1];
        out_data.item = dv_item_reg[DIV_STEPS-1];
        out_data.dlen = dv_dist_reg[DIV_STEPS-1];
        out_data.qx   = dv_qx_reg[DIV_STEPS-1];
        out_data.qy   = dv_qy_reg[DIV_STEPS-1];
    end

endmodule

// ----- rtl/dpcr_resp.sv -----
// Back end, second half: separation, damped impulse and saturating update,
// ending in the output register; uses dpcr_pkg.
module dpcr_resp (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       en,
    input  logic                       in_valid,
    input  dpcr_pkg::dpcr_norm_t       in_data,
    input  logic [dpcr_pkg::DAMP_W-1:0] damp,
    output logic                       out_valid,
    output dpcr_pkg::dpcr_res_t        out_data
);
    import dpcr_pkg::*;

    localparam int NX_W  = FRAC_BITS + 2;
    localparam int OVL_W = DIST_W + 1;
    localparam int DV_W  = POS_W + 1;
    localparam int SP_W  = OVL_W + NX_W;
    localparam int KP_W  = DV_W + NX_W;
    localparam int KS_W  = KP_W + 1;
    localparam int SEP_W = 28;
    localparam int K_W   = 36;
    localparam int KN_W  = K_W + NX_W;
    localparam int T_W   = 38;
    localparam int DM_W  = DAMP_W + 1;
    localparam int TD_W  = T_W + DM_W;
    localparam int IMP_W = 40;

    logic                     s_v_reg [9];
    dpcr_pair_t               s_pair_reg [8];
    logic                     s_hit_reg  [8];

    logic signed [NX_W-1:0]   s0_nx_reg, s0_ny_reg;
    logic signed [OVL_W-1:0]  s0_ovl_reg;
    logic signed [DV_W-1:0]   s0_dvx_reg, s0_dvy_reg;

    logic signed [SP_W-1:0]   s1_sxp_reg, s1_syp_reg;
    logic signed [KP_W-1:0]   s1_kxp_reg, s1_kyp_reg;
    logic signed [NX_W-1:0]   s1_nx_reg, s1_ny_reg;

    logic signed [SEP_W-1:0]  sx_reg [2:7];
    logic signed [SEP_W-1:0]  sy_reg [2:7];
    logic signed [NX_W-1:0]   nx_reg [2:3];
    logic signed [NX_W-1:0]   ny_reg [2:3];
    logic signed [KS_W-1:0]   s2_ksum_reg;
    logic signed [K_W-1:0]    s3_k_reg;
    logic signed [KN_W-1:0]   s4_knx_reg, s4_kny_reg;
    logic signed [T_W-1:0]    s5_tx_reg, s5_ty_reg;
    logic signed [TD_W-1:0]   s6_tdx_reg, s6_tdy_reg;
    logic signed [IMP_W-1:0]  s7_ix_reg, s7_iy_reg;

    dpcr_res_t                out_reg;

    logic signed [NX_W-1:0]   qx_s, qy_s;
    logic [DAMP_W-1:0]        damp_eff;
    logic signed [DM_W-1:0]   damp_s;
    logic signed [63:0]       t_sx, t_sy, t_k, t_tx, t_ty, t_ix, t_iy;
    dpcr_res_t                res_next;
    dpcr_pair_t               pr;

    always_comb
    begin
        qx_s     = signed'({1'b0, in_data.qx});
        qy_s     = signed'({1'b0, in_data.qy});
        damp_eff = (damp > DAMP_ONE) ? DAMP_ONE : damp;
        damp_s   = signed'({1'b0, damp_eff});
        t_sx = shr_tz(64'(s1_sxp_reg), FRAC_BITS + 1);
        t_sy = shr_tz(64'(s1_syp_reg), FRAC_BITS + 1);
        t_k  = shr_tz(64'(s2_ksum_reg), FRAC_BITS);
        t_tx = shr_tz(64'(s4_knx_reg), FRAC_BITS);
        t_ty = shr_tz(64'(s4_kny_reg), FRAC_BITS);
        t_ix = shr_tz(64'(s6_tdx_reg), 16);
        t_iy = shr_tz(64'(s6_tdy_reg), 16);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 9; i++)
            begin
                s_v_reg[i] <= 1'b0;
            end
        end
        else if (en)
        begin
            s_v_reg[0] <= in_valid;
            for (int i = 1; i < 9; i++)
            begin
                s_v_reg[i] <= s_v_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s_pair_reg[0] <= in_data.item.pair;
            s_hit_reg[0]  <= in_data.item.hit;
            for (int i = 1; i < 8; i++)
            begin
                s_pair_reg[i] <= s_pair_reg[i-1];
                s_hit_reg[i]  <= s_hit_reg[i-1];
            end

            s0_nx_reg  <= in_data.item.dx_neg ? -qx_s : qx_s;
            s0_ny_reg  <= in_data.item.dy_neg ? -qy_s : qy_s;
            s0_ovl_reg <= signed'({2'b0, in_data.item.rsum}) - signed'({1'b0, in_data.dlen});
            s0_dvx_reg <= DV_W'(in_data.item.pair.v2x) - DV_W'(in_data.item.pair.v1x);
            s0_dvy_reg <= DV_W'(in_data.item.pair.v2y) - DV_W'(in_data.item.pair.v1y);

            s1_sxp_reg <= s0_ovl_reg * s0_nx_reg;
            s1_syp_reg <= s0_ovl_reg * s0_ny_reg;
            s1_kxp_reg <= s0_dvx_reg * s0_nx_reg;
            s1_kyp_reg <= s0_dvy_reg * s0_ny_reg;
            s1_nx_reg  <= s0_nx_reg;
            s1_ny_reg  <= s0_ny_reg;

            sx_reg[2]   <= t_sx[SEP_W-1:0];
            sy_reg[2]   <= t_sy[SEP_W-1:0];
            s2_ksum_reg <= KS_W'(s1_kxp_reg) + KS_W'(s1_kyp_reg);
            nx_reg[2]   <= s1_nx_reg;
            ny_reg[2]   <= s1_ny_reg;

            s3_k_reg  <= t_k[K_W-1:0];
            nx_reg[3] <= nx_reg[2];
            ny_reg[3] <= ny_reg[2];

            s4_knx_reg <= s3_k_reg * nx_reg[3];
            s4_kny_reg <= s3_k_reg * ny_reg[3];

            s5_tx_reg <= t_tx[T_W-1:0];
            s5_ty_reg <= t_ty[T_W-1:0];

            s6_tdx_reg <= s5_tx_reg * damp_s;
            s6_tdy_reg <= s5_ty_reg * damp_s;

            s7_ix_reg <= t_ix[IMP_W-1:0];
            s7_iy_reg <= t_iy[IMP_W-1:0];

            for (int i = 3; i < 8; i++)
            begin
                sx_reg[i] <= sx_reg[i-1];
                sy_reg[i] <= sy_reg[i-1];
            end

            out_reg <= res_next;
        end
    end

    always_comb
    begin
        pr           = s_pair_reg[7];
        res_next.hit = s_hit_reg[7];
        if (s_hit_reg[7])
        begin
            res_next.p1x = sat32(64'(pr.p1x) - 64'(sx_reg[7]));
            res_next.p1y = sat32(64'(pr.p1y) - 64'(sy_reg[7]));
            res_next.p2x = sat32(64'(pr.p2x) + 64'(sx_reg[7]));
            res_next.p2y = sat32(64'(pr.p2y) + 64'(sy_reg[7]));
            res_next.v1x = sat32(64'(pr.v1x) + 64'(s7_ix_reg));
            res_next.v1y = sat32(64'(pr.v1y) + 64'(s7_iy_reg));
            res_next.v2x = sat32(64'(pr.v2x) - 64'(s7_ix_reg));
            res_next.v2y = sat32(64'(pr.v2y) - 64'(s7_iy_reg));
        end
        else
        begin
            res_next.p1x = pr.p1x;
            res_next.p1y = pr.p1y;
            res_next.p2x = pr.p2x;
            res_next.p2y = pr.p2y;
            res_next.v1x = pr.v1x;
            res_next.v1y = pr.v1y;
            res_next.v2x = pr.v2x;
            res_next.v2y = pr.v2y;
        end
    end

    assign out_valid = s_v_reg[8];
    assign out_data  = out_reg;

endmodule

// ----- rtl/disc_pair_collision_resolve.sv -----
// Disc pair collision response, top level. Throughput is one transaction
// per cycle when the output is not stalled; the pipelined square root (26
// stages) and normal divider (17 stages) set the depth. Reset clears all
// valid state and the queue and loads the damping register with 52429.
// Depends on dpcr_pkg, dpcr_front, dpcr_queue, dpcr_norm, dpcr_resp.
`include "assert_macros.svh"
module disc_pair_collision_resolve (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [31:0] first_pos_x,
    input  logic signed [31:0] first_pos_y,
    input  logic signed [31:0] first_vel_x,
    input  logic signed [31:0] first_vel_y,
    input  logic        [23:0] first_radius,
    input  logic signed [31:0] second_pos_x,
    input  logic signed [31:0] second_pos_y,
    input  logic signed [31:0] second_vel_x,
    input  logic signed [31:0] second_vel_y,
    input  logic        [23:0] second_radius,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               overlap_hit,
    output logic signed [31:0] new_first_pos_x,
    output logic signed [31:0] new_first_pos_y,
    output logic signed [31:0] new_first_vel_x,
    output logic signed [31:0] new_first_vel_y,
    output logic signed [31:0] new_second_pos_x,
    output logic signed [31:0] new_second_pos_y,
    output logic signed [31:0] new_second_vel_x,
    output logic signed [31:0] new_second_vel_y,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic        [16:0] cfg_data
);
    import dpcr_pkg::*;

    dpcr_pair_t        in_pair;
    logic              q_push;
    logic              q_pop;
    dpcr_qent_t        q_wdata;
    dpcr_qent_t        q_rdata;
    dpcr_qstat_t       q_stat;
    logic              back_en;
    logic              norm_valid;
    dpcr_norm_t        norm_data;
    dpcr_res_t         res;
    logic [DAMP_W-1:0] damp_reg;

    always_comb
    begin
        in_pair.p1x = first_pos_x;
        in_pair.p1y = first_pos_y;
        in_pair.v1x = first_vel_x;
        in_pair.v1y = first_vel_y;
        in_pair.r1  = first_radius;
        in_pair.p2x = second_pos_x;
        in_pair.p2y = second_pos_y;
        in_pair.v2x = second_vel_x;
        in_pair.v2y = second_vel_y;
        in_pair.r2  = second_radius;
    end

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            damp_reg <= DAMP_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            damp_reg <= cfg_data;
        end
    end

    dpcr_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_pair  (in_pair),
        .q_full   (q_stat.full),
        .q_push   (q_push),
        .q_data   (q_wdata)
    );

    dpcr_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_wdata),
        .pop       (q_pop),
        .pop_data  (q_rdata),
        .stat      (q_stat)
    );

    assign back_en = !out_valid || !out_stall;
    assign q_pop   = back_en && !q_stat.empty;

    dpcr_norm u_norm (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (back_en),
        .in_valid  (!q_stat.empty),
        .in_data   (q_rdata),
        .out_valid (norm_valid),
        .out_data  (norm_data)
    );

    dpcr_resp u_resp (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (back_en),
        .in_valid  (norm_valid),
        .in_data   (norm_data),
        .damp      (damp_reg),
        .out_valid (out_valid),
        .out_data  (res)
    );

    always_comb
    begin
        overlap_hit      = res.hit;
        new_first_pos_x  = res.p1x;
        new_first_pos_y  = res.p1y;
        new_first_vel_x  = res.v1x;
        new_first_vel_y  = res.v1y;
        new_second_pos_x = res.p2x;
        new_second_pos_y = res.p2y;
        new_second_vel_x = res.v2x;
        new_second_vel_y = res.v2y;
    end

    `ASSERT_ALWAYS(a_queue_bound, clk, rst_n, q_stat.count <= QCNT_W'(QDEPTH))
    `ASSERT_IMPLY(a_no_push_full, clk, rst_n, q_push, !q_stat.full)
    `ASSERT_ALWAYS(a_empty_match, clk, rst_n, (q_stat.count == '0) == q_stat.empty)

endmodule
